// ----- sv/rar_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rar_pkg;

  // operand width taken from each 32-bit input field (8 to 32)
  localparam int OPERAND_BITS = 32;
  // width of products, sums and everything reduced by the gcd
  localparam int PROD_BITS    = 2 * OPERAND_BITS;
  localparam int SH_BITS      = $clog2(PROD_BITS);
  localparam int CNT_BITS     = $clog2(PROD_BITS + 1);

  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_SUB = 3'd1;
  localparam logic [2:0] CMD_MUL = 3'd2;
  localparam logic [2:0] CMD_DIV = 3'd3;
  localparam logic [2:0] CMD_RED = 3'd4;

  typedef struct packed {
    logic        [2:0]  cmd;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } req_t;

  typedef struct packed {
    logic signed [63:0] res_num;
    logic        [62:0] res_den;
    logic               div_zero;
  } rsp_t;

  typedef struct packed {
    logic                    neg;
    logic [OPERAND_BITS-1:0] mag;
  } sgn_mag_t;

  // sign and magnitude of the low OPERAND_BITS bits; the most negative
  // value maps onto its own bit pattern, which is the right magnitude
  function automatic sgn_mag_t split(input logic [31:0] raw);
    sgn_mag_t                r;
    logic [OPERAND_BITS-1:0] v;
    v     = raw[OPERAND_BITS-1:0];
    r.neg = v[OPERAND_BITS-1];
    r.mag = r.neg ? (~v + 1'b1) : v;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/rar_gcd.sv -----
`timescale 1ns / 1ps
`default_nettype none

// binary gcd, one shift or one subtract per cycle, then the common
// power of two is put back one bit per cycle
module rar_gcd (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          go,
  input  wire logic [rar_pkg::PROD_BITS-1:0] u_in,
  input  wire logic [rar_pkg::PROD_BITS-1:0] v_in,
  output logic                               done,
  output logic      [rar_pkg::PROD_BITS-1:0] g
);

  typedef enum logic [1:0] {G_IDLE, G_RUN, G_SHIFT} gstate_t;

  gstate_t                        state;
  logic [rar_pkg::PROD_BITS-1:0]  u;
  logic [rar_pkg::PROD_BITS-1:0]  v;
  logic [rar_pkg::SH_BITS-1:0]    sh;

  assign g = u;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= G_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        G_IDLE: begin
          if (go) begin
            u     <= u_in;
            v     <= v_in;
            sh    <= '0;
            state <= G_RUN;
          end
        end
        G_RUN: begin
          if (u == '0 || v == '0) begin
            u     <= u | v;
            state <= G_SHIFT;
          end else if (!u[0] && !v[0]) begin
            u  <= u >> 1;
            v  <= v >> 1;
            sh <= sh + 1'b1;
          end else if (!u[0]) begin
            u <= u >> 1;
          end else if (!v[0]) begin
            v <= v >> 1;
          end else if (u >= v) begin
            u <= u - v;
          end else begin
            v <= v - u;
          end
        end
        G_SHIFT: begin
          if (sh == '0) begin
            done  <= 1'b1;
            state <= G_IDLE;
          end else begin
            u  <= u << 1;
            sh <= sh - 1'b1;
          end
        end
        default: state <= G_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/rar_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per cycle
module rar_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          go,
  input  wire logic [rar_pkg::PROD_BITS-1:0] dvd,
  input  wire logic [rar_pkg::PROD_BITS-1:0] dvs,
  output logic                               done,
  output logic      [rar_pkg::PROD_BITS-1:0] quo
);

  logic                           run;
  logic [rar_pkg::PROD_BITS-1:0]  q;
  logic [rar_pkg::PROD_BITS-1:0]  r;
  logic [rar_pkg::PROD_BITS-1:0]  d;
  logic [rar_pkg::CNT_BITS-1:0]   cnt;
  logic [rar_pkg::PROD_BITS-1:0]  r2;

  assign quo = q;
  assign r2  = {r[rar_pkg::PROD_BITS-2:0], q[rar_pkg::PROD_BITS-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!run) begin
        if (go) begin
          q   <= dvd;
          r   <= '0;
          d   <= dvs;
          cnt <= rar_pkg::CNT_BITS'(rar_pkg::PROD_BITS);
          run <= 1'b1;
        end
      end else begin
        if (r2 >= d) begin
          r <= r2 - d;
          q <= {q[rar_pkg::PROD_BITS-2:0], 1'b1};
        end else begin
          r <= r2;
          q <= {q[rar_pkg::PROD_BITS-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == rar_pkg::CNT_BITS'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/rational_arith_reduce.sv -----
`timescale 1ns / 1ps
`default_nettype none

// rational arithmetic with gcd reduction. An item carries a command (add,
// subtract, multiply, divide, or reduce a alone; unused codes reduce a)
// and two rationals a_num/a_den and b_num/b_den, each field taken as its
// low OPERAND_BITS bits in two's complement. The result comes back in
// lowest terms with a positive denominator and the sign on the numerator;
// a zero numerator gives 0/1, and a nonzero numerator over zero (in an
// operand or in the result) gives 0/0 with div_zero set. One item is
// worked at a time: a single 32x32 multiplier forms up to three cross
// products, a binary gcd unit takes one shift or subtract per cycle and
// then shifts the common power of two back in, and one restoring divider
// divides the numerator and then the denominator by the gcd at one bit
// per cycle. Items that end in zero or error skip the gcd and divider.
// req_stall stays high while an item is in work; a finished result sits
// in the output register, so the next item can be taken while it waits.
module rational_arith_reduce (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire rar_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output rar_pkg::rsp_t      rsp
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_COMB, S_CHK, S_GCD, S_DIVN, S_DIVD, S_OUT
  } state_t;

  state_t state;

  // operands after zero normalization
  logic [2:0]                       cmd;
  logic [rar_pkg::OPERAND_BITS-1:0] an, ad, bn, bd;
  logic                             a_neg, b_neg, a_err, b_err;

  // cross products and the working fraction
  logic [rar_pkg::PROD_BITS-1:0]    t1, t2, t3;
  logic [rar_pkg::PROD_BITS-1:0]    rnum, rden, g, qn;
  logic                             rneg, rerr;

  // operand split at the input
  rar_pkg::sgn_mag_t sa_n, sa_d, sb_n, sb_d;
  assign sa_n = rar_pkg::split(req.a_num);
  assign sa_d = rar_pkg::split(req.a_den);
  assign sb_n = rar_pkg::split(req.b_num);
  assign sb_d = rar_pkg::split(req.b_den);

  logic is_addsub, is_mul, is_div, is_red;
  assign is_addsub = (cmd == rar_pkg::CMD_ADD) || (cmd == rar_pkg::CMD_SUB);
  assign is_mul    = (cmd == rar_pkg::CMD_MUL);
  assign is_div    = (cmd == rar_pkg::CMD_DIV);
  assign is_red    = !(is_addsub || is_mul || is_div);

  // the one multiplier, its product registered into t1/t2/t3
  logic [rar_pkg::OPERAND_BITS-1:0] mul_x, mul_y;
  logic [rar_pkg::PROD_BITS-1:0]    prod;

  always_comb begin
    case (state)
      S_MUL1: begin
        mul_x = an;
        mul_y = is_mul ? bn : bd;
      end
      S_MUL2: begin
        mul_x = ad;
        mul_y = is_mul ? bd : bn;
      end
      default: begin
        mul_x = ad;
        mul_y = bd;
      end
    endcase
  end

  assign prod = rar_pkg::PROD_BITS'(mul_x) * rar_pkg::PROD_BITS'(mul_y);

  // signed combine for add and subtract
  logic                          s1, s2, sn;
  logic [rar_pkg::PROD_BITS-1:0] m;

  always_comb begin
    s1 = a_neg;
    s2 = (cmd == rar_pkg::CMD_SUB) ? !b_neg : b_neg;
    if (s1 == s2) begin
      m  = t1 + t2;
      sn = s1;
    end else if (t1 >= t2) begin
      m  = t1 - t2;
      sn = s1;
    end else begin
      m  = t2 - t1;
      sn = s2;
    end
  end

  // gcd and divider
  logic                          gcd_go, gcd_done;
  logic [rar_pkg::PROD_BITS-1:0] gcd_g;
  logic                          div_go, div_done;
  logic [rar_pkg::PROD_BITS-1:0] div_dvd, div_dvs, div_quo;

  assign gcd_go  = (state == S_CHK) && !rerr && (rnum != '0) && (rden != '0);
  assign div_go  = ((state == S_GCD) && gcd_done) || ((state == S_DIVN) && div_done);
  assign div_dvd = (state == S_GCD) ? rnum : rden;
  assign div_dvs = (state == S_GCD) ? gcd_g : g;

  rar_gcd u_gcd (
    .clk  (clk),
    .rst  (rst),
    .go   (gcd_go),
    .u_in (rnum),
    .v_in (rden),
    .done (gcd_done),
    .g    (gcd_g)
  );

  rar_div u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .dvd  (div_dvd),
    .dvs  (div_dvs),
    .done (div_done),
    .quo  (div_quo)
  );

  assign req_stall = (state != S_IDLE);

  // result numerator magnitude as 64 bits; the sign is applied at the output
  logic [63:0] num_ext;
  assign num_ext = 64'(rnum);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      // the output state reloads the register itself
      if (rsp_valid && !rsp_stall && state != S_OUT) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            cmd <= req.cmd;
            // a zero numerator makes the operand 0/1 whatever its denominator
            if (sa_n.mag == '0) begin
              an    <= '0;
              ad    <= rar_pkg::OPERAND_BITS'(1);
              a_neg <= 1'b0;
              a_err <= 1'b0;
            end else begin
              an    <= sa_n.mag;
              ad    <= sa_d.mag;
              a_neg <= sa_n.neg ^ sa_d.neg;
              a_err <= (sa_d.mag == '0);
            end
            if (sb_n.mag == '0) begin
              bn    <= '0;
              bd    <= rar_pkg::OPERAND_BITS'(1);
              b_neg <= 1'b0;
              b_err <= 1'b0;
            end else begin
              bn    <= sb_n.mag;
              bd    <= sb_d.mag;
              b_neg <= sb_n.neg ^ sb_d.neg;
              b_err <= (sb_d.mag == '0);
            end
            state <= S_MUL1;
          end
        end
        S_MUL1: begin
          t1    <= prod;
          state <= S_MUL2;
        end
        S_MUL2: begin
          t2    <= prod;
          state <= is_addsub ? S_MUL3 : S_COMB;
        end
        S_MUL3: begin
          t3    <= prod;
          state <= S_COMB;
        end
        S_COMB: begin
          if (is_red) begin
            rnum <= rar_pkg::PROD_BITS'(an);
            rden <= rar_pkg::PROD_BITS'(ad);
            rneg <= a_neg;
            rerr <= a_err;
          end else if (a_err || b_err) begin
            rerr <= 1'b1;
          end else if (is_addsub) begin
            rnum <= m;
            rden <= t3;
            rneg <= sn;
            rerr <= 1'b0;
          end else begin
            rnum <= t1;
            rden <= t2;
            rneg <= a_neg ^ b_neg;
            rerr <= 1'b0;
          end
          state <= S_CHK;
        end
        S_CHK: begin
          // zero numerator wins over a zero denominator
          if (rerr) begin
            state <= S_OUT;
          end else if (rnum == '0) begin
            rden  <= rar_pkg::PROD_BITS'(1);
            rneg  <= 1'b0;
            state <= S_OUT;
          end else if (rden == '0) begin
            rerr  <= 1'b1;
            state <= S_OUT;
          end else begin
            state <= S_GCD;
          end
        end
        S_GCD: begin
          if (gcd_done) begin
            g     <= gcd_g;
            state <= S_DIVN;
          end
        end
        S_DIVN: begin
          if (div_done) begin
            qn    <= div_quo;
            state <= S_DIVD;
          end
        end
        S_DIVD: begin
          if (div_done) begin
            rnum  <= qn;
            rden  <= div_quo;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          // wait for the output register to be free
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid <= 1'b1;
            if (rerr) begin
              rsp.res_num  <= '0;
              rsp.res_den  <= '0;
              rsp.div_zero <= 1'b1;
            end else begin
              rsp.res_num  <= rneg ? (64'd0 - num_ext) : num_ext;
              rsp.res_den  <= 63'(rden);
              rsp.div_zero <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
